>>> hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and codes for the go-back-N sender window
// Action and result codes, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // input action codes
  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SENT   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_SLID   = 2'd2;
  localparam logic [1:0] ST_RESEND = 2'd3;

  // configuration register indexes
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_STEP   = 1'b1;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned STEP_W = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1024;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SLIDE,
    S_SLID_OUT,
    S_REPLAY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       capture_in;   // latch the accepted item
    logic       send_commit;  // advance next_free and next_sequence
    logic       load_out;     // load the output register
    logic [1:0] out_sel;      // status code of the loaded result
    logic       slide_init;   // start a slide: remainder and count
    logic       slide_step;   // retire one outstanding slot
    logic       rem_sub;      // take one step off the remainder
    logic       replay_init;  // start a replay from the oldest slot
    logic       replay_step;  // advance to the next slot to resend
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       ack_ge;       // captured ack at or above expected_ack
    logic       outs_zero;    // nothing outstanding
    logic       full;         // outstanding count at window size
    logic       left_zero;
    logic       left_one;
    logic       rem_lt_step;
    logic       out_free;     // output register can take a result
  } sts_t;

endpackage

>>> hw/rtl/go_back_n_sender_window.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window: sender-side go-back-N window controller
// Keeps the ring of segment slots and the sequence counters, assigns slots
// to new segments, slides on acknowledgements and replays on loss.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per request (send, acknowledgement, timeout).
//   out_* : result items; last marks the final result of an item.
//   cfg_* : index 0 window_size, index 1 seq_step; always ready; to be written
//           only while the block is idle, which the user and not the block ensures.
//           Writing window_size empties the ring.
// Timing: one item at a time. An item is accepted in the idle state and
//   decided in the next cycle. A send loads its result once the output
//   register is free. An acknowledgement slides one slot per cycle until
//   no outstanding slot is left or the remainder is below the step,
//   retiring at most the window, then loads its result. A replay emits one
//   resend per cycle from the oldest slot while the output register is
//   free. The next item is taken in the cycle after the last result is loaded.
// Reset: window 4, step 1024, ring empty, sequence numbers zero.
// Stall: results sit in a single output register; while it is held the
//   controller waits to load a result, though a slide still retires slots.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
  parameter int MAX_WINDOW = 16,
  localparam int SLOT_W    = $clog2(MAX_WINDOW + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [gbn_pkg::STEP_W-1:0]  cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [gbn_pkg::SEQ_W-1:0]   ack_number,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [SLOT_W-1:0]           slot,
  output logic [gbn_pkg::SEQ_W-1:0]   seq_number,
  output logic                        last
);

  gbn_pkg::cmd_t cmd;
  gbn_pkg::sts_t sts;

  // configuration is taken whenever offered
  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (action),
    .ack_number (ack_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .slot       (slot),
    .seq_number (seq_number),
    .last       (last),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

>>> hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl: sequencing controller for the go-back-N sender window
// Takes one item at a time, decides the action from datapath status and
// steps the slide or replay loop one slot per cycle; replay waits on out_free.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gbn_pkg::sts_t sts,
  output gbn_pkg::cmd_t cmd
);

  gbn_pkg::state_t state;
  gbn_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbn_pkg::S_IDLE: begin
        if (in_valid) state_next = gbn_pkg::S_DECIDE;
      end
      gbn_pkg::S_DECIDE: begin
        priority if (sts.action == gbn_pkg::ACT_SEND) begin
          if (sts.out_free) state_next = gbn_pkg::S_IDLE;
        end else if (sts.action == gbn_pkg::ACT_ACK && sts.ack_ge) begin
          state_next = gbn_pkg::S_SLIDE;
        end else if (sts.action == gbn_pkg::ACT_ACK ||
                     sts.action == gbn_pkg::ACT_TIMEOUT) begin
          state_next = sts.outs_zero ? gbn_pkg::S_IDLE : gbn_pkg::S_REPLAY;
        end else begin
          state_next = gbn_pkg::S_IDLE;
        end
      end
      gbn_pkg::S_SLIDE: begin
        if (sts.left_zero || sts.rem_lt_step) state_next = gbn_pkg::S_SLID_OUT;
      end
      gbn_pkg::S_SLID_OUT: begin
        if (sts.out_free) state_next = gbn_pkg::S_IDLE;
      end
      gbn_pkg::S_REPLAY: begin
        if (sts.out_free && sts.left_one) state_next = gbn_pkg::S_IDLE;
      end
      default: state_next = gbn_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      gbn_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        cmd.capture_in = in_valid;
      end
      gbn_pkg::S_DECIDE: begin
        priority if (sts.action == gbn_pkg::ACT_SEND) begin
          cmd.load_out    = sts.out_free;
          cmd.out_sel     = sts.full ? gbn_pkg::ST_FULL : gbn_pkg::ST_SENT;
          cmd.send_commit = sts.out_free && !sts.full;
        end else if (sts.action == gbn_pkg::ACT_ACK && sts.ack_ge) begin
          cmd.slide_init = 1'b1;
        end else if (sts.action == gbn_pkg::ACT_ACK ||
                     sts.action == gbn_pkg::ACT_TIMEOUT) begin
          cmd.replay_init = 1'b1;
        end else begin
          cmd = '0;
        end
      end
      gbn_pkg::S_SLIDE: begin
        cmd.slide_step = !sts.left_zero;
        cmd.rem_sub    = !sts.left_zero && !sts.rem_lt_step;
      end
      gbn_pkg::S_SLID_OUT: begin
        cmd.load_out = sts.out_free;
        cmd.out_sel  = gbn_pkg::ST_SLID;
      end
      gbn_pkg::S_REPLAY: begin
        cmd.load_out    = sts.out_free;
        cmd.out_sel     = gbn_pkg::ST_RESEND;
        cmd.replay_step = sts.out_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp: datapath for the go-back-N sender window
// Configuration, ring pointers, sequence counters, slide and replay
// counters, and the result register.
// ----------------------------------------------------------------------------
module gbn_dp #(
  parameter int MAX_WINDOW = 16,
  localparam int SLOT_W    = $clog2(MAX_WINDOW + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gbn_pkg::STEP_W-1:0]  cfg_data,
  // input item
  input  logic [1:0]                  action,
  input  logic [gbn_pkg::SEQ_W-1:0]   ack_number,
  // result
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [SLOT_W-1:0]           slot,
  output logic [gbn_pkg::SEQ_W-1:0]   seq_number,
  output logic                        last,
  // control
  input  gbn_pkg::cmd_t               cmd,
  output gbn_pkg::sts_t               sts
);

  localparam int WIN_RESET = (4 > MAX_WINDOW) ? MAX_WINDOW : 4;

  // effective configuration
  logic [SLOT_W-1:0]          win;
  logic [gbn_pkg::STEP_W-1:0] step;
  // window state
  logic [SLOT_W-1:0]          first_outstanding;
  logic [SLOT_W-1:0]          next_free;
  logic [gbn_pkg::SEQ_W-1:0]  expected_ack;
  logic [gbn_pkg::SEQ_W-1:0]  next_sequence;
  // captured item and loop state
  logic [1:0]                 act_q;
  logic [gbn_pkg::SEQ_W-1:0]  ack_q;
  logic [gbn_pkg::SEQ_W-1:0]  rem;
  logic [SLOT_W-1:0]          left;
  logic [SLOT_W-1:0]          rp_slot;
  logic [gbn_pkg::SEQ_W-1:0]  rp_seq;

  logic [SLOT_W:0]            outs_wide;
  logic [SLOT_W-1:0]          outs;
  logic [gbn_pkg::SEQ_W-1:0]  step_ext;
  logic                       out_free;

  function automatic logic [SLOT_W-1:0] ring_inc(input logic [SLOT_W-1:0] x,
                                                 input logic [SLOT_W-1:0] top);
    return (x == top) ? '0 : SLOT_W'(x + 1'b1);
  endfunction

  assign step_ext = {{(gbn_pkg::SEQ_W - gbn_pkg::STEP_W){1'b0}}, step};
  assign out_free = !out_valid || out_ready;

  // outstanding count around a ring of win+1 slots
  always_comb begin
    if (next_free >= first_outstanding) begin
      outs_wide = {1'b0, next_free} - {1'b0, first_outstanding};
    end else begin
      outs_wide = {1'b0, next_free} + {1'b0, win} + 1'b1 - {1'b0, first_outstanding};
    end
    outs = outs_wide[SLOT_W-1:0];
  end

  // status to controller
  always_comb begin
    sts.action      = act_q;
    sts.ack_ge      = ack_q >= expected_ack;
    sts.outs_zero   = outs == '0;
    sts.full        = outs >= win;
    sts.left_zero   = left == '0;
    sts.left_one    = left == SLOT_W'(1);
    sts.rem_lt_step = rem < step_ext;
    sts.out_free    = out_free;
  end

  // configuration registers, stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= SLOT_W'(WIN_RESET);
      step <= gbn_pkg::STEP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == gbn_pkg::CFG_WINDOW) begin
        if (cfg_data[4:0] == 5'd0) begin
          win <= SLOT_W'(1);
        end else if (int'(cfg_data[4:0]) > MAX_WINDOW) begin
          win <= SLOT_W'(MAX_WINDOW);
        end else begin
          win <= SLOT_W'(cfg_data[4:0]);
        end
      end else begin
        step <= (cfg_data == '0) ? gbn_pkg::STEP_W'(1) : cfg_data;
      end
    end
  end

  // ring pointers and sequence numbers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_outstanding <= '0;
      next_free         <= '0;
      expected_ack      <= '0;
      next_sequence     <= '0;
    end else if (cfg_we && cfg_index == gbn_pkg::CFG_WINDOW) begin
      first_outstanding <= '0;
      next_free         <= '0;
      expected_ack      <= next_sequence;
    end else begin
      if (cmd.send_commit) begin
        next_free     <= ring_inc(next_free, win);
        next_sequence <= next_sequence + step_ext;
      end
      if (cmd.slide_step) begin
        first_outstanding <= ring_inc(first_outstanding, win);
        expected_ack      <= expected_ack + step_ext;
      end
    end
  end

  // captured item, slide and replay counters
  always_ff @(posedge clk) begin
    if (cmd.capture_in) begin
      act_q <= action;
      ack_q <= ack_number;
    end
    if (cmd.slide_init) begin
      rem  <= ack_q - expected_ack;
      left <= outs;
    end else if (cmd.replay_init) begin
      left    <= outs;
      rp_slot <= first_outstanding;
      rp_seq  <= expected_ack;
    end else begin
      if (cmd.rem_sub) rem <= rem - step_ext;
      if (cmd.slide_step || cmd.replay_step) left <= left - 1'b1;
      if (cmd.replay_step) begin
        rp_slot <= ring_inc(rp_slot, win);
        rp_seq  <= rp_seq + step_ext;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= cmd.out_sel;
      unique case (cmd.out_sel)
        gbn_pkg::ST_SENT, gbn_pkg::ST_FULL: begin
          slot       <= next_free;
          seq_number <= next_sequence;
          last       <= 1'b1;
        end
        gbn_pkg::ST_SLID: begin
          slot       <= first_outstanding;
          seq_number <= expected_ack;
          last       <= 1'b1;
        end
        default: begin
          slot       <= rp_slot;
          seq_number <= rp_seq;
          last       <= left == SLOT_W'(1);
        end
      endcase
    end
  end

  // ring pointers stay inside the ring
  a_ptr_in_ring: assert property (@(posedge clk) disable iff (rst)
    (first_outstanding <= win) && (next_free <= win))
    else $error("ring pointer beyond window");

  // never more outstanding than the window allows
  a_outs_in_window: assert property (@(posedge clk) disable iff (rst)
    outs <= win)
    else $error("outstanding count exceeds window");

  // a result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result overwrites a pending result");

  // slide and replay never step past their count
  a_left_guard: assert property (@(posedge clk) disable iff (rst)
    (cmd.slide_step || cmd.replay_step) |-> (left != '0))
    else $error("loop step with zero count");

endmodule
